// ===== hdl/pitr_pkg.sv =====
// ----------------------------------------------------------------------------
// pitr_pkg
// Types and constants shared by the PI throttle regulator modules.
// ----------------------------------------------------------------------------
package pitr_pkg;

	localparam int SPEED_W = 16;
	localparam int GAIN_W  = 16;
	localparam int INTEG_W = 32;
	localparam int IDX_W   = 2;

	// Register reset values: gains in unsigned Q8.8, clamp limit in throttle units.
	localparam logic [GAIN_W-1:0]  PROP_GAIN_RST    = 16'd2077;
	localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST   = 16'd128;
	localparam logic [SPEED_W-1:0] THROTTLE_MAX_RST = 16'd11520;

	typedef enum logic [IDX_W-1:0] {
		REG_PROP_GAIN    = 2'd0,
		REG_INTEG_GAIN   = 2'd1,
		REG_THROTTLE_MAX = 2'd2
	} reg_idx_t;

	// Outcome of one control step, handed from the datapath to the top level.
	typedef struct packed {
		logic [INTEG_W-1:0] integral;
		logic [SPEED_W-1:0] throttle;
		logic               clamped;
	} step_t;

endpackage

// ===== hdl/pi_throttle_regulator_antiwindup_top.sv =====
// ----------------------------------------------------------------------------
// pi_throttle_regulator_antiwindup_top
// PI throttle regulator with conditional-integration anti-windup.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is one control step and yields exactly one
// throttle transfer on the output channel. A step is held in the input register
// while the error, integral update, both gain products and the clamp are
// computed, and then lands in the output register. One step can be taken every
// cycle while out_ready is high; a stalled output holds the input register.
// The integral and saturated flag are updated as each step leaves the input
// register, so the next step in the following cycle sees them. Configuration
// writes (index 0 prop_gain, 1 integ_gain, 2 throttle_max, other indexes
// ignored) are always ready and take effect on the next step computed.
module pi_throttle_regulator_antiwindup_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              going_on,
	input  logic [pitr_pkg::SPEED_W-1:0]      target_speed,
	input  logic [pitr_pkg::SPEED_W-1:0]      measured_speed,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [pitr_pkg::SPEED_W-1:0]      throttle,
	output logic                              clamped,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pitr_pkg::IDX_W-1:0]        cfg_index,
	input  logic [pitr_pkg::GAIN_W-1:0]       cfg_data
);
	import pitr_pkg::*;

	logic [GAIN_W-1:0]  prop_gain_q;
	logic [GAIN_W-1:0]  integ_gain_q;
	logic [SPEED_W-1:0] throttle_max_q;

	logic [INTEG_W-1:0] integral_q;
	logic               saturated_q;

	logic               valid_s1;
	logic               going_on_s1;
	logic [SPEED_W-1:0] target_s1;
	logic [SPEED_W-1:0] measured_s1;

	logic               valid_s2;
	logic [SPEED_W-1:0] throttle_s2;
	logic               clamped_s2;

	logic               advance;
	step_t              step;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;

	assign out_valid = valid_s2;
	assign throttle  = throttle_s2;
	assign clamped   = clamped_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q    <= PROP_GAIN_RST;
			integ_gain_q   <= INTEG_GAIN_RST;
			throttle_max_q <= THROTTLE_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PROP_GAIN:    prop_gain_q    <= cfg_data;
				REG_INTEG_GAIN:   integ_gain_q   <= cfg_data;
				REG_THROTTLE_MAX: throttle_max_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	pitr_step u_step (
		.going_on       (going_on_s1),
		.target_speed   (target_s1),
		.measured_speed (measured_s1),
		.prop_gain      (prop_gain_q),
		.integ_gain     (integ_gain_q),
		.throttle_max   (throttle_max_q),
		.integral       (integral_q),
		.saturated      (saturated_q),
		.step           (step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			integral_q  <= '0;
			saturated_q <= 1'b1;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2    <= 1'b1;
				integral_q  <= step.integral;
				saturated_q <= step.clamped;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			going_on_s1 <= going_on;
			target_s1   <= target_speed;
			measured_s1 <= measured_speed;
		end
		if (advance) begin
			throttle_s2 <= step.throttle;
			clamped_s2  <= step.clamped;
		end
	end

	// The saturated flag must follow the clamp of the step just moved into the output register.
	a_sat_tracks_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (saturated_q == clamped_s2))
		else $error("saturated flag does not match last clamp");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && going_on_s1) |=> (integral_q == '0))
		else $error("restart did not clear the integral");

	a_unclamped_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !step.clamped) |-> (step.throttle <= throttle_max_q))
		else $error("unclamped throttle above limit");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled with empty input register");

endmodule

// ===== hdl/pitr_step.sv =====
// ----------------------------------------------------------------------------
// pitr_step
// One PI control step: error, conditional integration with saturation,
// gain products, shift and clamp.
// ----------------------------------------------------------------------------
module pitr_step (
	input  logic                              going_on,
	input  logic [pitr_pkg::SPEED_W-1:0]      target_speed,
	input  logic [pitr_pkg::SPEED_W-1:0]      measured_speed,
	input  logic [pitr_pkg::GAIN_W-1:0]       prop_gain,
	input  logic [pitr_pkg::GAIN_W-1:0]       integ_gain,
	input  logic [pitr_pkg::SPEED_W-1:0]      throttle_max,
	input  logic [pitr_pkg::INTEG_W-1:0]      integral,
	input  logic                              saturated,
	output pitr_pkg::step_t                   step
);
	import pitr_pkg::*;

	logic signed [16:0] err;
	logic signed [31:0] integ_base;
	logic               hold;
	logic signed [32:0] integ_sum;
	logic signed [31:0] integ_new;
	logic signed [33:0] prop_prod;
	logic signed [48:0] integ_prod;
	logic signed [49:0] acc;
	logic        [41:0] cmd;

	always_comb begin
		err = $signed({1'b0, target_speed}) - $signed({1'b0, measured_speed});

		// A restart clears the integral and blocks integration for this step.
		integ_base = going_on ? 32'sd0 : $signed(integral);
		hold       = going_on | saturated;

		integ_sum = $signed({integ_base[31], integ_base}) +
			$signed({{16{err[16]}}, err});
		if (hold) begin
			integ_new = integ_base;
		end else if (integ_sum[32] != integ_sum[31]) begin
			integ_new = integ_sum[32] ? $signed(32'h8000_0000) : $signed(32'h7FFF_FFFF);
		end else begin
			integ_new = integ_sum[31:0];
		end

		prop_prod  = $signed({1'b0, prop_gain}) * err;
		integ_prod = $signed({1'b0, integ_gain}) * integ_new;
		acc = $signed({{16{prop_prod[33]}}, prop_prod}) +
			$signed({integ_prod[48], integ_prod});
		cmd = acc[49:8];

		step.integral = integ_new;
		if (acc[49]) begin
			step.throttle = '0;
			step.clamped  = 1'b1;
		end else if (cmd > {26'd0, throttle_max}) begin
			step.throttle = throttle_max;
			step.clamped  = 1'b1;
		end else begin
			step.throttle = cmd[15:0];
			step.clamped  = 1'b0;
		end
	end

endmodule
